FILE: hdl/aedf_pkg.sv
// Shared types and constants for the ADC averaging and debounce filter.
// Used by every module of the block; depends on nothing else.
package aedf_pkg;

    // Sample and fixed-point geometry.
    localparam int ADC_BITS   = 12;
    localparam int N_SAMPLES  = 4;
    localparam int AVG_SHIFT  = 2;
    localparam int SUM_W      = ADC_BITS + AVG_SHIFT;
    localparam int FRAC_BITS  = 16;
    localparam int FILT_W     = ADC_BITS + FRAC_BITS;
    localparam int DIFF_W     = FILT_W + 1;
    localparam int ALPHA_W    = 17;
    localparam int PROD_W     = DIFF_W + ALPHA_W + 1;
    localparam int STEP_W     = PROD_W - FRAC_BITS;
    localparam int VOLT_W     = 13;
    localparam int VPROD_W    = ADC_BITS + VOLT_W;
    localparam int THR_W      = 12;
    localparam int CNT_W      = 8;

    localparam logic [ADC_BITS-1:0] ADC_MAX   = {ADC_BITS{1'b1}};
    localparam logic [ALPHA_W-1:0]  ALPHA_ONE = ALPHA_W'(1) << FRAC_BITS;
    localparam logic [FILT_W-1:0]   FILT_TOP  = {ADC_MAX, {FRAC_BITS{1'b0}}};
    localparam logic [FILT_W:0]     ROUND_HALF = (FILT_W+1)'(1) << (FRAC_BITS - 1);
    localparam logic [CNT_W-1:0]    CNT_MAX   = {CNT_W{1'b1}};

    // Queue between front and back.
    localparam int QUEUE_DEPTH_DEF = 2;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 17;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ALPHA     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANGE_THRESHOLD = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STABLE_COUNT     = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_MILLIVOLTS   = 8'd3;

    localparam logic [ALPHA_W-1:0] ALPHA_RST = 17'd6554;
    localparam logic [THR_W-1:0]   THR_RST   = 12'd4;
    localparam logic [CNT_W-1:0]   COUNT_RST = 8'd3;
    localparam logic [VOLT_W-1:0]  REF_RST   = 13'd3300;

    typedef struct packed {
        logic [ADC_BITS-1:0] sample_0;
        logic [ADC_BITS-1:0] sample_1;
        logic [ADC_BITS-1:0] sample_2;
        logic [ADC_BITS-1:0] sample_3;
    } t_in;

    typedef struct packed {
        logic [ADC_BITS-1:0] raw_average;
        logic [ADC_BITS-1:0] published_value;
        logic [VOLT_W-1:0]   voltage_mv;
        logic                new_value;
    } t_out;

    typedef struct packed {
        logic [ALPHA_W-1:0] filter_alpha;
        logic [THR_W-1:0]   change_threshold;
        logic [CNT_W-1:0]   stable_count;
        logic [VOLT_W-1:0]  ref_millivolts;
    } t_cfg;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_UPD,
        S_CMP,
        S_VMUL,
        S_VDIV
    } t_back_state;

endpackage

FILE: hdl/aedf_front.sv
// Front stage: takes input transfers and reduces the four samples to their mean.
// Depends on aedf_pkg; feeds aedf_queue.
module aedf_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  aedf_pkg::t_in                 i_in_data,
    output logic                          o_push,
    output logic [aedf_pkg::ADC_BITS-1:0] o_push_data,
    input  aedf_pkg::t_q_status           i_q_status
);

    logic                          r_valid;
    logic [aedf_pkg::ADC_BITS-1:0] r_avg;
    logic [aedf_pkg::SUM_W-1:0]    sum;
    logic                          accept;

    // Sum of the four samples, truncated mean by shifting.
    assign sum = aedf_pkg::SUM_W'(i_in_data.sample_0) + aedf_pkg::SUM_W'(i_in_data.sample_1)
               + aedf_pkg::SUM_W'(i_in_data.sample_2) + aedf_pkg::SUM_W'(i_in_data.sample_3);

    assign o_push      = r_valid && !i_q_status.full;
    assign o_push_data = r_avg;
    assign o_in_ready  = !r_valid || o_push;
    assign accept      = i_in_valid && o_in_ready;

    // Holding register for one averaged item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_avg <= aedf_pkg::ADC_BITS'(sum >> aedf_pkg::AVG_SHIFT);
        end
    end

endmodule

FILE: hdl/aedf_queue.sv
// Small FIFO of averaged samples between the front stage and the filter engine.
// Depends on aedf_pkg for the status struct.
module aedf_queue #(
    parameter int DEPTH = aedf_pkg::QUEUE_DEPTH_DEF,
    parameter int WIDTH = aedf_pkg::ADC_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic [WIDTH-1:0]    i_push_data,
    input  logic                i_pop,
    output logic [WIDTH-1:0]    o_data,
    output aedf_pkg::t_q_status o_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_data         = r_mem[r_rd_ptr];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    // The front never offers an item into a full queue.
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.full |-> !i_push)
        else $error("queue push while full");

    // Fill count stays within depth.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count out of range");

endmodule

FILE: hdl/aedf_back.sv
// Filter engine: EMA update, debounce decision, voltage scaling and the result register.
// Depends on aedf_pkg; pops averaged samples from aedf_queue.
module aedf_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  aedf_pkg::t_cfg                i_cfg,
    input  aedf_pkg::t_q_status           i_q_status,
    input  logic [aedf_pkg::ADC_BITS-1:0] i_q_data,
    output logic                          o_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output aedf_pkg::t_out                o_out_data
);

    localparam int AB = aedf_pkg::ADC_BITS;
    localparam int FW = aedf_pkg::FILT_W;

    aedf_pkg::t_back_state r_state;
    aedf_pkg::t_back_state n_state;

    logic                               r_filter_ready;
    logic [AB-1:0]                      r_avg;
    logic signed [aedf_pkg::DIFF_W-1:0] r_diff;
    logic [aedf_pkg::ALPHA_W-1:0]       r_alpha;
    logic signed [aedf_pkg::PROD_W-1:0] r_prod;
    logic [FW-1:0]                      r_filtered;
    logic [AB-1:0]                      r_val;
    logic                               r_update;
    logic                               r_pub_now;
    logic [aedf_pkg::CNT_W-1:0]         r_counter;
    logic [AB-1:0]                      r_last;
    logic [aedf_pkg::VOLT_W-1:0]        r_volt;
    logic [aedf_pkg::VPROD_W-1:0]       r_vprod;
    logic                               r_out_valid;
    aedf_pkg::t_out                     r_out;

    logic                               out_free;
    logic signed [aedf_pkg::DIFF_W-1:0] diff;
    logic signed [aedf_pkg::PROD_W-1:0] prod;
    logic signed [aedf_pkg::STEP_W-1:0] step;
    logic signed [aedf_pkg::STEP_W-1:0] next_sum;
    logic [FW-1:0]                      next_filt;
    logic [FW:0]                        rnd_sum;
    logic [AB:0]                        rnd_wide;
    logic [AB-1:0]                      rnd;
    logic [AB-1:0]                      gap;
    logic [aedf_pkg::CNT_W-1:0]         cnt_inc;
    logic [aedf_pkg::VOLT_W-1:0]        q0;
    logic [aedf_pkg::VOLT_W:0]          rem0;
    logic [1:0]                         fold;
    logic [aedf_pkg::VOLT_W-1:0]        q1;
    logic [aedf_pkg::VOLT_W-1:0]        rem1;
    logic [aedf_pkg::VOLT_W-1:0]        volt;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_pop       = (r_state == aedf_pkg::S_IDLE) && !i_q_status.empty;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Distance from the new average to the running filter value.
    assign diff = $signed({1'b0, i_q_data, {aedf_pkg::FRAC_BITS{1'b0}}})
                - $signed({1'b0, r_filtered});

    // Alpha-weighted step; the arithmetic shift by 16 is the upper slice.
    assign prod     = r_diff * $signed({1'b0, r_alpha});
    assign step     = r_prod[aedf_pkg::PROD_W-1:aedf_pkg::FRAC_BITS];
    assign next_sum = $signed({{(aedf_pkg::STEP_W-FW){1'b0}}, r_filtered}) + step;

    // Clamp the updated filter to the valid fixed-point range.
    always_comb begin
        if (next_sum[aedf_pkg::STEP_W-1]) begin
            next_filt = '0;
        end else if (next_sum > $signed(aedf_pkg::STEP_W'(aedf_pkg::FILT_TOP))) begin
            next_filt = aedf_pkg::FILT_TOP;
        end else begin
            next_filt = next_sum[FW-1:0];
        end
    end

    // Round half up, then measure the gap to the published value.
    assign rnd_sum  = {1'b0, r_filtered} + aedf_pkg::ROUND_HALF;
    assign rnd_wide = rnd_sum[FW:aedf_pkg::FRAC_BITS];
    assign rnd      = (rnd_wide > (AB+1)'(aedf_pkg::ADC_MAX)) ? aedf_pkg::ADC_MAX
                                                                 : rnd_wide[AB-1:0];
    assign gap      = (rnd > r_last) ? (rnd - r_last) : (r_last - rnd);
    assign cnt_inc  = (r_counter == aedf_pkg::CNT_MAX) ? r_counter : r_counter + 1'b1;

    // Floor division by 4095: fold the high part back twice, then one correction.
    assign q0   = r_vprod[aedf_pkg::VPROD_W-1:AB];
    assign rem0 = (aedf_pkg::VOLT_W+1)'(r_vprod[AB-1:0]) + (aedf_pkg::VOLT_W+1)'(q0);
    assign fold = rem0[AB+1:AB];
    assign q1   = q0 + aedf_pkg::VOLT_W'(fold);
    assign rem1 = aedf_pkg::VOLT_W'(rem0[AB-1:0]) + aedf_pkg::VOLT_W'(fold);
    assign volt = q1 + aedf_pkg::VOLT_W'(rem1 >= aedf_pkg::VOLT_W'(aedf_pkg::ADC_MAX));

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= aedf_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state: the first item after reset skips the EMA steps.
    always_comb begin
        n_state = r_state;
        case (r_state)
            aedf_pkg::S_IDLE: begin
                if (o_pop) begin
                    n_state = r_filter_ready ? aedf_pkg::S_MUL : aedf_pkg::S_VMUL;
                end
            end
            aedf_pkg::S_MUL:  n_state = aedf_pkg::S_UPD;
            aedf_pkg::S_UPD:  n_state = aedf_pkg::S_CMP;
            aedf_pkg::S_CMP:  n_state = aedf_pkg::S_VMUL;
            aedf_pkg::S_VMUL: n_state = aedf_pkg::S_VDIV;
            aedf_pkg::S_VDIV: begin
                if (out_free) begin
                    n_state = aedf_pkg::S_IDLE;
                end
            end
            default: n_state = aedf_pkg::S_IDLE;
        endcase
    end

    // Control flags: filter initialized and result register occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_ready <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (o_pop) begin
                r_filter_ready <= 1'b1;
            end
            if (r_state == aedf_pkg::S_VDIV && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers, advanced by the sequencer.
    always_ff @(posedge i_clk) begin
        case (r_state)
            aedf_pkg::S_IDLE: begin
                if (o_pop) begin
                    r_avg   <= i_q_data;
                    r_diff  <= diff;
                    r_alpha <= (i_cfg.filter_alpha > aedf_pkg::ALPHA_ONE)
                               ? aedf_pkg::ALPHA_ONE : i_cfg.filter_alpha;
                    if (!r_filter_ready) begin
                        r_filtered <= {i_q_data, {aedf_pkg::FRAC_BITS{1'b0}}};
                        r_val      <= i_q_data;
                        r_update   <= 1'b1;
                        r_pub_now  <= 1'b0;
                        r_counter  <= '0;
                    end
                end
            end
            aedf_pkg::S_MUL: begin
                r_prod <= prod;
            end
            aedf_pkg::S_UPD: begin
                r_filtered <= next_filt;
            end
            aedf_pkg::S_CMP: begin
                r_val <= rnd;
                if (gap > i_cfg.change_threshold) begin
                    if (cnt_inc >= i_cfg.stable_count) begin
                        r_counter <= '0;
                        r_update  <= 1'b1;
                        r_pub_now <= 1'b1;
                    end else begin
                        r_counter <= cnt_inc;
                        r_update  <= 1'b0;
                        r_pub_now <= 1'b0;
                    end
                end else begin
                    r_counter <= '0;
                    r_update  <= 1'b0;
                    r_pub_now <= 1'b0;
                end
            end
            aedf_pkg::S_VMUL: begin
                r_vprod <= aedf_pkg::VPROD_W'(r_val) * aedf_pkg::VPROD_W'(i_cfg.ref_millivolts);
            end
            aedf_pkg::S_VDIV: begin
                if (out_free) begin
                    if (r_update) begin
                        r_last <= r_val;
                        r_volt <= volt;
                    end
                    r_out.raw_average     <= r_avg;
                    r_out.published_value <= r_update ? r_val : r_last;
                    r_out.voltage_mv      <= r_update ? volt : r_volt;
                    r_out.new_value       <= r_pub_now;
                end
            end
            default: begin
            end
        endcase
    end

    // A new item is taken only from the idle state.
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state == aedf_pkg::S_MUL || r_state == aedf_pkg::S_VMUL))
        else $error("pop outside idle sequencing");

    // Once initialized, the filter value stays within full scale.
    a_filt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_filter_ready && r_state != aedf_pkg::S_IDLE |-> r_filtered <= aedf_pkg::FILT_TOP)
        else $error("filter value above full scale");

    // A publish flag always comes with an update of the published value.
    a_pub_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == aedf_pkg::S_VDIV && r_pub_now |-> r_update)
        else $error("publish without update");

endmodule

FILE: hdl/adc_ema_debounce_filter.sv
// Top level of the ADC averaging, EMA smoothing and debounced publishing block.
// Depends on aedf_pkg, aedf_front, aedf_queue and aedf_back.
//
//   Channel | Direction | Signals                                   | Content
//   --------+-----------+-------------------------------------------+---------------------------
//   in      | input     | i_in_valid, o_in_ready, i_in_data         | four raw ADC samples
//   out     | output    | o_out_valid, i_out_ready, o_out_data      | average, published value
//   cfg     | input     | i_cfg_valid, o_cfg_ready, i_cfg_index/data| register writes
//
// The front takes one transfer per cycle into a single holding register and a small queue,
// but stalls while both are full. The filter engine takes each item through these steps:
// pop, multiply by alpha, update and clamp, debounce decision, voltage multiply, divide;
// the first item after reset skips the EMA steps. A new item is popped only once the last is done.
// Reset is synchronous and active low; configuration returns to its default values.
// A stalled output holds the engine in its last step while the front and queue keep filling.
module adc_ema_debounce_filter #(
    parameter int QUEUE_DEPTH = aedf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  aedf_pkg::t_in                  i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output aedf_pkg::t_out                 o_out_data,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [aedf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [aedf_pkg::CFG_DAT_W-1:0] i_cfg_data
);

    aedf_pkg::t_cfg                r_cfg;
    aedf_pkg::t_q_status           q_status;
    logic                          push;
    logic [aedf_pkg::ADC_BITS-1:0] push_data;
    logic                          pop;
    logic [aedf_pkg::ADC_BITS-1:0] q_data;

    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.filter_alpha     <= aedf_pkg::ALPHA_RST;
            r_cfg.change_threshold <= aedf_pkg::THR_RST;
            r_cfg.stable_count     <= aedf_pkg::COUNT_RST;
            r_cfg.ref_millivolts   <= aedf_pkg::REF_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                aedf_pkg::CFG_FILTER_ALPHA: begin
                    r_cfg.filter_alpha <= i_cfg_data[aedf_pkg::ALPHA_W-1:0];
                end
                aedf_pkg::CFG_CHANGE_THRESHOLD: begin
                    r_cfg.change_threshold <= i_cfg_data[aedf_pkg::THR_W-1:0];
                end
                aedf_pkg::CFG_STABLE_COUNT: begin
                    r_cfg.stable_count <= i_cfg_data[aedf_pkg::CNT_W-1:0];
                end
                aedf_pkg::CFG_REF_MILLIVOLTS: begin
                    r_cfg.ref_millivolts <= i_cfg_data[aedf_pkg::VOLT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    aedf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_push      (push),
        .o_push_data (push_data),
        .i_q_status  (q_status)
    );

    aedf_queue #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (aedf_pkg::ADC_BITS)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_data      (q_data),
        .o_status    (q_status)
    );

    aedf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_status  (q_status),
        .i_q_data    (q_data),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
